// File: src/efd_pkg.sv
package efd_pkg;

    localparam logic [7:0] BYTE_FLAG   = 8'h7E;
    localparam logic [7:0] BYTE_ESCAPE = 8'h7D;
    localparam logic [7:0] BYTE_SUFFIX = 8'h00;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_B = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_CODE_C = 2'd2;

    localparam logic [7:0] TYPE_CODE_A_RST = 8'd0;
    localparam logic [7:0] TYPE_CODE_B_RST = 8'd1;
    localparam logic [7:0] TYPE_CODE_C_RST = 8'd2;

    localparam logic [1:0] CLS_OTHER  = 2'd0;
    localparam logic [1:0] CLS_FLAG   = 2'd1;
    localparam logic [1:0] CLS_ESCAPE = 2'd2;
    localparam logic [1:0] CLS_SUFFIX = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] cls;
        logic       hit_lit;
        logic       hit_esc;
    } t_token;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] packet_kind;
        logic       last_of_packet;
    } t_result;

endpackage

// File: src/efd_fifo.sv
module efd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: src/efd_front.sv
module efd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [efd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic [7:0]                       i_rx_byte,
    output efd_pkg::t_token                  o_token
);

    logic [7:0] r_type_a;
    logic [7:0] r_type_b;
    logic [7:0] r_type_c;
    logic [7:0] esc_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_a <= efd_pkg::TYPE_CODE_A_RST;
            r_type_b <= efd_pkg::TYPE_CODE_B_RST;
            r_type_c <= efd_pkg::TYPE_CODE_C_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                efd_pkg::REG_TYPE_CODE_A: r_type_a <= i_cfg_data;
                efd_pkg::REG_TYPE_CODE_B: r_type_b <= i_cfg_data;
                efd_pkg::REG_TYPE_CODE_C: r_type_c <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // value the byte stands for when it follows an escape
    assign esc_value = (i_rx_byte == efd_pkg::BYTE_SUFFIX) ? efd_pkg::BYTE_ESCAPE : i_rx_byte;

    always_comb begin
        o_token.data = i_rx_byte;
        case (i_rx_byte)
            efd_pkg::BYTE_FLAG:   o_token.cls = efd_pkg::CLS_FLAG;
            efd_pkg::BYTE_ESCAPE: o_token.cls = efd_pkg::CLS_ESCAPE;
            efd_pkg::BYTE_SUFFIX: o_token.cls = efd_pkg::CLS_SUFFIX;
            default:              o_token.cls = efd_pkg::CLS_OTHER;
        endcase
        o_token.hit_lit = (i_rx_byte == r_type_a) || (i_rx_byte == r_type_b)
                          || (i_rx_byte == r_type_c);
        o_token.hit_esc = (esc_value == r_type_a) || (esc_value == r_type_b)
                          || (esc_value == r_type_c);
    end

endmodule

// File: src/efd_back.sv
module efd_back #(
    parameter int MAX_PAYLOAD = efd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_empty,
    input  efd_pkg::t_token  i_token,
    output logic             o_tok_pop,
    input  logic             i_out_ready,
    output logic             o_out_push,
    output efd_pkg::t_result o_result
);

    logic       r_boundary_seen;
    logic       r_escape_pending;
    logic       r_kind_known;
    logic [7:0] r_kind_value;
    logic       r_length_known;
    logic [7:0] r_length;
    logic [7:0] r_count;

    logic       n_boundary_seen;
    logic       n_escape_pending;
    logic       n_kind_known;
    logic [7:0] n_kind_value;
    logic       n_length_known;
    logic [7:0] n_length;
    logic [7:0] n_count;

    logic       take;
    logic       decoded;
    logic [7:0] dec_value;
    logic       dec_hit;
    logic       restart;
    logic       emit;
    logic       last;
    logic [7:0] count_inc;

    assign take      = !i_tok_empty && i_out_ready;
    assign o_tok_pop = take;
    assign count_inc = r_count + 8'd1;

    always_comb begin
        decoded   = 1'b0;
        restart   = 1'b0;
        dec_value = i_token.data;
        dec_hit   = i_token.hit_lit;
        n_boundary_seen  = r_boundary_seen;
        n_escape_pending = r_escape_pending;
        if (!r_boundary_seen) begin
            if (i_token.cls == efd_pkg::CLS_FLAG) begin
                n_boundary_seen = 1'b1;
            end
        end else if (!r_escape_pending) begin
            if (i_token.cls == efd_pkg::CLS_ESCAPE) begin
                n_escape_pending = 1'b1;
            end else if (i_token.cls == efd_pkg::CLS_FLAG) begin
                restart = 1'b1;
            end else begin
                decoded = 1'b1;
            end
        end else begin
            n_escape_pending = 1'b0;
            if (i_token.cls == efd_pkg::CLS_FLAG) begin
                decoded = 1'b1;
            end else if (i_token.cls == efd_pkg::CLS_SUFFIX) begin
                decoded   = 1'b1;
                dec_value = efd_pkg::BYTE_ESCAPE;
                dec_hit   = i_token.hit_esc;
            end else begin
                restart = 1'b1;
            end
        end
    end

    always_comb begin
        emit           = 1'b0;
        last           = 1'b0;
        n_kind_known   = r_kind_known;
        n_kind_value   = r_kind_value;
        n_length_known = r_length_known;
        n_length       = r_length;
        n_count        = r_count;
        if (restart) begin
            n_kind_known   = 1'b0;
            n_kind_value   = 8'd0;
            n_length_known = 1'b0;
            n_length       = 8'd0;
            n_count        = 8'd0;
        end else if (decoded) begin
            if (!r_kind_known) begin
                if (dec_hit) begin
                    n_kind_known = 1'b1;
                    n_kind_value = dec_value;
                end
            end else if (!r_length_known) begin
                n_length_known = 1'b1;
                n_length       = dec_value;
                n_count        = 8'd0;
                last           = (dec_value == 8'd0);
            end else if (r_count < 8'(MAX_PAYLOAD)) begin
                n_count = count_inc;
                emit    = 1'b1;
                last    = (count_inc == r_length);
            end
        end
    end

    assign o_out_push              = take && (emit || last);
    assign o_result.payload_byte   = emit ? dec_value : 8'd0;
    assign o_result.payload_valid  = emit;
    assign o_result.packet_kind    = r_kind_value;
    assign o_result.last_of_packet = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boundary_seen  <= 1'b0;
            r_escape_pending <= 1'b0;
            r_kind_known     <= 1'b0;
            r_kind_value     <= 8'd0;
            r_length_known   <= 1'b0;
            r_length         <= 8'd0;
            r_count          <= 8'd0;
        end else if (take) begin
            if (last) begin
                // packet complete, back to hunting
                r_boundary_seen  <= 1'b0;
                r_escape_pending <= 1'b0;
                r_kind_known     <= 1'b0;
                r_kind_value     <= 8'd0;
                r_length_known   <= 1'b0;
                r_length         <= 8'd0;
                r_count          <= 8'd0;
            end else begin
                r_boundary_seen  <= n_boundary_seen;
                r_escape_pending <= n_escape_pending;
                r_kind_known     <= n_kind_known;
                r_kind_value     <= n_kind_value;
                r_length_known   <= n_length_known;
                r_length         <= n_length;
                r_count          <= n_count;
            end
        end
    end

    a_last_rehunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_result.last_of_packet) |=> (!r_boundary_seen && !r_kind_known))
        else $error("packet end did not return to hunting");

    a_length_needs_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length_known |-> r_kind_known)
        else $error("length known without packet kind");

    a_escape_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape_pending |-> r_boundary_seen)
        else $error("escape pending while hunting");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 8'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_ready && !i_tok_empty))
        else $error("result pushed without room");

endmodule

// File: src/escaped_frame_deframer.sv
// Byte-stuffed frame receiver: takes one raw byte per clock from push/full, hunts for a
// 0x7E flag, undoes 0x7D escapes, picks the packet kind (first byte matching one of the
// three type code registers), the length byte and then streams payload bytes out through
// empty/pop. Sustained rate is one byte per clock; a byte is registered in the token queue,
// then its result in the result queue. A two-entry queue sits between byte classification
// and the packet state machine and a second one holds results, so input stalls only once
// both queues are full. Payload beyond MAX_PAYLOAD bytes is dropped and such a packet ends
// at a flag or bad escape. Configuration writes are always ready and should be done while idle.
module escaped_frame_deframer #(
    parameter int MAX_PAYLOAD = efd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_rx_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_payload_byte,
    output logic                            o_payload_valid,
    output logic [7:0]                      o_packet_kind,
    output logic                            o_last_of_packet,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [efd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    efd_pkg::t_token  front_token;
    efd_pkg::t_token  back_token;
    efd_pkg::t_result back_result;
    efd_pkg::t_result out_result;
    logic             tok_empty;
    logic             tok_pop;
    logic             out_full;
    logic             out_push;
    logic             out_ready;
    logic             in_take;

    assign o_cfg_ready = 1'b1;
    assign in_take     = push && !full;
    assign out_ready   = !out_full || pop;

    efd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_rx_byte),
        .o_token     (front_token)
    );

    efd_fifo #(
        .WIDTH ($bits(efd_pkg::t_token))
    ) u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_take),
        .i_data  (front_token),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (back_token),
        .o_empty (tok_empty)
    );

    efd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_empty (tok_empty),
        .i_token     (back_token),
        .o_tok_pop   (tok_pop),
        .i_out_ready (out_ready),
        .o_out_push  (out_push),
        .o_result    (back_result)
    );

    efd_fifo #(
        .WIDTH ($bits(efd_pkg::t_result))
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop && !empty),
        .o_data  (out_result),
        .o_empty (empty)
    );

    assign o_payload_byte   = out_result.payload_byte;
    assign o_payload_valid  = out_result.payload_valid;
    assign o_packet_kind    = out_result.packet_kind;
    assign o_last_of_packet = out_result.last_of_packet;

endmodule
